/* rtl/dma_request_frame_builder_assert.svh */
// Assertion macros shared by the frame builder checks.
`ifndef DMA_REQUEST_FRAME_BUILDER_ASSERT_SVH
`define DMA_REQUEST_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define DMARFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define DMARFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define DMARFB_ASSERT_ANY(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dmarfb_pkg.sv */
package dmarfb_pkg;

    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 14;
    localparam int BYTE_W    = 8;
    localparam int HDR_BYTES = 5;

    localparam logic [BYTE_W-1:0] START_BYTE   = 8'h87;
    localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'h0D;

    localparam logic REG_READ_OPCODE  = 1'b0;
    localparam logic REG_WRITE_OPCODE = 1'b1;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_DATA  = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_STEP,
        ST_RD_EMIT,
        ST_WR_OPEN,
        ST_WR_HDR,
        ST_WR_PAY,
        ST_WR_TAIL,
        ST_WR_NEXT
    } t_step;

    typedef enum logic {
        SRC_FRAME,
        SRC_DATA
    } t_src;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_DIV,
        ACT_OPEN,
        ACT_ADV
    } t_act;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_FRAME_MORE,
        C_HDR_MORE,
        C_CHUNK_MORE,
        C_REM
    } t_cond;

    // One control word: once the step fires, go to jmp if cond holds, else to nxt.
    typedef struct packed {
        logic  emit;
        t_src  src;
        logic  wr;
        t_act  act;
        t_cond cond;
        t_step jmp;
        t_step nxt;
    } t_uop;

    typedef struct packed {
        logic out_free;
        logic len_nz;
        logic rem_nz;
        logic frame_more;
        logic hdr_more;
        logic chunk_more;
    } t_dp_stat;

    function automatic t_uop ucode_rom(input t_step s);
        t_uop u;
        u = '{1'b0, SRC_FRAME, 1'b0, ACT_NONE, C_ALWAYS, ST_IDLE, ST_IDLE};
        case (s)
            ST_DIV_STEP: u = '{1'b0, SRC_FRAME, 1'b0, ACT_DIV,  C_ALWAYS,
                               ST_RD_EMIT, ST_RD_EMIT};
            ST_RD_EMIT:  u = '{1'b1, SRC_FRAME, 1'b0, ACT_NONE, C_FRAME_MORE,
                               ST_RD_EMIT, ST_IDLE};
            ST_WR_OPEN:  u = '{1'b0, SRC_FRAME, 1'b1, ACT_OPEN, C_ALWAYS,
                               ST_WR_HDR, ST_WR_HDR};
            ST_WR_HDR:   u = '{1'b1, SRC_FRAME, 1'b1, ACT_NONE, C_HDR_MORE,
                               ST_WR_HDR, ST_IDLE};
            ST_WR_PAY:   u = '{1'b1, SRC_DATA,  1'b1, ACT_NONE, C_CHUNK_MORE,
                               ST_IDLE, ST_WR_TAIL};
            ST_WR_TAIL:  u = '{1'b1, SRC_FRAME, 1'b1, ACT_NONE, C_FRAME_MORE,
                               ST_WR_TAIL, ST_WR_NEXT};
            ST_WR_NEXT:  u = '{1'b0, SRC_FRAME, 1'b1, ACT_ADV,  C_REM,
                               ST_WR_OPEN, ST_IDLE};
            default: ;
        endcase
        return u;
    endfunction

endpackage

/* rtl/dmarfb_useq.sv */
module dmarfb_useq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_in_op,
    input  dmarfb_pkg::t_dp_stat i_stat,
    output logic                 o_in_ready,
    output dmarfb_pkg::t_uop     o_uop,
    output logic                 o_fire
);
    import dmarfb_pkg::*;

    t_step r_step;
    t_step n_step;
    t_uop  uop;
    logic  cond_ok;

    assign uop        = ucode_rom(r_step);
    assign o_uop      = uop;
    assign o_in_ready = (r_step == ST_IDLE);
    // emitting steps wait for room in the output register
    assign o_fire     = !uop.emit || i_stat.out_free;

    always_comb begin
        case (uop.cond)
            C_ALWAYS:     cond_ok = 1'b1;
            C_FRAME_MORE: cond_ok = i_stat.frame_more;
            C_HDR_MORE:   cond_ok = i_stat.hdr_more;
            C_CHUNK_MORE: cond_ok = i_stat.chunk_more;
            C_REM:        cond_ok = i_stat.rem_nz;
            default:      cond_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (r_step == ST_IDLE) begin
            if (i_in_valid) begin
                case (t_op'(i_in_op))
                    OP_READ:  n_step = ST_DIV_STEP;
                    OP_WRITE: n_step = i_stat.len_nz ? ST_WR_OPEN : ST_IDLE;
                    OP_DATA:  n_step = i_stat.rem_nz ? ST_WR_PAY : ST_IDLE;
                    default:  n_step = ST_IDLE;
                endcase
            end
        end else if (o_fire) begin
            n_step = cond_ok ? uop.jmp : uop.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

/* rtl/dmarfb_dp.sv */
module dmarfb_dp #(
    parameter int BODY_BYTES  = 44,
    parameter int FRAME_BYTES = 51
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [1:0]                       i_op,
    input  logic [dmarfb_pkg::ADDR_W-1:0]    i_address,
    input  logic [dmarfb_pkg::LEN_W-1:0]     i_length,
    input  logic [dmarfb_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic [dmarfb_pkg::BYTE_W-1:0]    i_read_opcode,
    input  logic [dmarfb_pkg::BYTE_W-1:0]    i_write_opcode,
    input  dmarfb_pkg::t_uop                 i_uop,
    input  logic                             i_fire,
    output dmarfb_pkg::t_dp_stat             o_stat,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [dmarfb_pkg::BYTE_W-1:0]    o_byte,
    output logic                             o_last
);
    import dmarfb_pkg::*;

    localparam int CAP     = (BODY_BYTES < FRAME_BYTES - 7) ? BODY_BYTES : FRAME_BYTES - 7;
    localparam int POS_W   = $clog2(FRAME_BYTES);
    localparam int CSZ_W   = $clog2(CAP + 1);
    localparam int QW      = LEN_W + 1;
    localparam int RCP_SH  = QW + 8;
    localparam int RCP     = ((1 << RCP_SH) + BODY_BYTES - 1) / BODY_BYTES;
    localparam int RCP_W   = RCP_SH + 1;
    localparam int PROD_W  = QW + RCP_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] SUM_POS  = POS_W'(FRAME_BYTES - 2);

    logic [POS_W-1:0]  r_pos;
    logic [LEN_W-1:0]  r_rem;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_addr;
    logic [CSZ_W-1:0]  r_csize;
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] r_data;
    logic [QW-1:0]     r_q;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic [PROD_W-1:0] div_prod;
    logic [BYTE_W-1:0] frame_byte;
    logic [BYTE_W-1:0] emit_byte;
    logic              do_emit;
    logic              do_pay;

    assign do_emit = i_fire && i_uop.emit;
    assign do_pay  = do_emit && (i_uop.src == SRC_DATA);

    // packet count by reciprocal multiply, exact for every 15-bit dividend
    assign div_prod = PROD_W'(r_q) * PROD_W'(RCP);

    always_comb begin
        frame_byte = '0;
        if (r_pos == LAST_POS) begin
            frame_byte = TRAILER_BYTE;
        end else if (r_pos == SUM_POS) begin
            frame_byte = r_sum;
        end else begin
            case (r_pos)
                POS_W'(0): frame_byte = START_BYTE;
                POS_W'(1): frame_byte = i_uop.wr ? BYTE_W'(r_csize) : r_q[BYTE_W-1:0];
                POS_W'(2): frame_byte = i_uop.wr ? i_write_opcode : i_read_opcode;
                POS_W'(3): frame_byte = i_uop.wr ? r_addr[15:8] : r_addr[31:24];
                POS_W'(4): frame_byte = i_uop.wr ? r_addr[7:0] : r_addr[23:16];
                POS_W'(5): frame_byte = i_uop.wr ? '0 : r_addr[15:8];
                POS_W'(6): frame_byte = i_uop.wr ? '0 : r_addr[7:0];
                default:   frame_byte = '0;
            endcase
        end
    end

    assign emit_byte = (i_uop.src == SRC_DATA) ? r_data : frame_byte;

    assign o_stat.out_free   = !r_out_valid || i_ready;
    assign o_stat.len_nz     = (i_length != '0);
    assign o_stat.rem_nz     = (r_rem != '0);
    assign o_stat.frame_more = (r_pos != LAST_POS);
    assign o_stat.hdr_more   = (r_pos != POS_W'(HDR_BYTES - 1));
    assign o_stat.chunk_more = (POS_W'(r_pos + 1'b1) != POS_W'(HDR_BYTES + int'(r_csize)));

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_accept) begin
                case (t_op'(i_op))
                    OP_READ: begin
                        r_pos <= '0;
                        r_rem <= '0;
                    end
                    OP_WRITE: begin
                        r_pos <= '0;
                        r_rem <= i_length;
                    end
                    default: ;
                endcase
            end else begin
                if (do_emit) begin
                    r_pos <= (r_pos == LAST_POS) ? '0 : POS_W'(r_pos + 1'b1);
                end
                if (do_pay) begin
                    r_rem <= r_rem - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_data <= i_data_byte;
            if (t_op'(i_op) == OP_READ || t_op'(i_op) == OP_WRITE) begin
                r_addr <= i_address;
            end
            if (t_op'(i_op) == OP_READ) begin
                r_q <= QW'(i_length) + QW'(BODY_BYTES - 1);
            end
        end else if (i_fire) begin
            case (i_uop.act)
                ACT_DIV: begin
                    r_q <= div_prod[RCP_SH +: QW];
                end
                ACT_OPEN: begin
                    r_csize <= (r_rem < LEN_W'(CAP)) ? CSZ_W'(r_rem) : CSZ_W'(CAP);
                end
                ACT_ADV: begin
                    r_addr[15:0] <= r_addr[15:0] + 16'(CAP);
                end
                default: ;
            endcase
        end
        if (do_emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= (r_pos == LAST_POS);
            r_sum      <= (r_pos == '0) ? emit_byte : r_sum + emit_byte;
        end
    end

endmodule

/* rtl/dma_request_frame_builder.sv */
// Read start: the request is accepted, the divide step computes the packet count,
// then 51 frame bytes at one per cycle while the sink keeps up.
// Write start: the chunk is sized, then 5 header bytes. Each payload byte has its
// own emit step; the byte that fills a chunk adds padding, checksum, trailer, an
// address step and, if bytes remain, a sizing step and the next header.
// Synchronous active-low reset: sequencer idle, output empty, opcodes 0 and 1.
module dma_request_frame_builder #(
    parameter int BODY_BYTES  = 44,
    parameter int FRAME_BYTES = 51
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // address[31:0], length[45:32], data_byte[53:46]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dmarfb_pkg::*;

    logic [BYTE_W-1:0] r_read_opcode;
    logic [BYTE_W-1:0] r_write_opcode;
    logic              cfg_wr;
    logic              in_accept;
    t_uop              uop;
    logic              fire;
    t_dp_stat          stat;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_WRITE_OPCODE) ? {24'd0, r_write_opcode}
                                                      : {24'd0, r_read_opcode};
    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_opcode  <= 8'h00;
            r_write_opcode <= 8'h01;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_READ_OPCODE:  r_read_opcode  <= pwdata[BYTE_W-1:0];
                REG_WRITE_OPCODE: r_write_opcode <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    dmarfb_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_uop      (uop),
        .o_fire     (fire)
    );

    dmarfb_dp #(
        .BODY_BYTES  (BODY_BYTES),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_op           (s_axis_tuser),
        .i_address      (s_axis_tdata[31:0]),
        .i_length       (s_axis_tdata[45:32]),
        .i_data_byte    (s_axis_tdata[53:46]),
        .i_read_opcode  (r_read_opcode),
        .i_write_opcode (r_write_opcode),
        .i_uop          (uop),
        .i_fire         (fire),
        .o_stat         (stat),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_byte         (m_axis_tdata),
        .o_last         (m_axis_tlast)
    );

endmodule

/* rtl/dmarfb_checker.sv */
`include "dma_request_frame_builder_assert.svh"

module dmarfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);
    import dmarfb_pkg::*;

    `DMARFB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")
    `DMARFB_ASSERT_IMP(a_last_trailer, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata == TRAILER_BYTE, "frame end is not the trailer byte")
    `DMARFB_ASSERT_NXT(a_read_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_READ, !s_axis_tready, "read request did not start count step")
    `DMARFB_ASSERT_ANY(a_reset_state, i_clk, !i_rst_n, !m_axis_tvalid && s_axis_tready, "not idle after reset")

endmodule

bind dma_request_frame_builder dmarfb_checker u_dmarfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
